// File: src/gcr_pkg.sv
// Shared constants, operation codes and payload types for the gradient color ramp.
package gcr_pkg;

    localparam int MAX_STOPS = 16;
    localparam int IDX_W     = $clog2(MAX_STOPS);
    localparam int CNT_W     = $clog2(MAX_STOPS + 1);
    localparam int POS_W     = 17;
    localparam int CH_W      = 8;
    localparam int RGB_W     = 3 * CH_W;
    localparam int FRAC_W    = 16;
    localparam int Q_W       = FRAC_W + 1;
    localparam int REM_W     = POS_W + 1;
    localparam int DIV_STEPS = FRAC_W + 1;
    localparam int DSTEP_W   = $clog2(DIV_STEPS);
    localparam int ACC_W     = CH_W + 1 + Q_W + 1;
    localparam int HALF_Q16  = 1 << (FRAC_W - 1);

    localparam logic [RGB_W-1:0] WHITE_RGB = '1;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [POS_W-1:0] position;
        logic [CH_W-1:0]  stop_red;
        logic [CH_W-1:0]  stop_green;
        logic [CH_W-1:0]  stop_blue;
    } gcr_in_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            status;
    } gcr_out_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [RGB_W-1:0] rgb;
    } gcr_stop_t;

endpackage

// File: src/gradient_colour_ramp.sv
// Gradient color ramp: sorted stop table with sequenced insert and lookup.
//
// Usage: present a beat on item and raise start while busy is low; the beat is
// taken on that edge. Exactly one result beat follows, shown on result for a
// single cycle with done high; there is no back-pressure, so the receiver must
// capture it then. Clear, a refused add (table full, status 1), an add into an
// empty table, a lookup in an empty table and the unused operation code finish
// at once: done rises the cycle after acceptance and busy never rises. An add
// into a table holding n > 0 stops walks the table from the top, one entry per
// cycle through the stop memory (one write and one read port), moving larger
// stops up by one. A lookup reads the stops one per cycle until it finds the
// enclosing segment, then runs a restoring divider that produces one weight
// bit per cycle, then a decision state, and in smooth mode a blend state in
// which one shared signed multiplier blends red, green and blue in turn.
// Empty table reads white, one stop reads its color, positions outside the
// stops read the end color, and a zero-width segment reads the later stop.
// smooth_mode is written through cfg_we/cfg_wdata and must only change while
// the block is idle.
module gradient_colour_ramp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gcr_pkg::gcr_in_t  item,
    output logic              done,
    output gcr_pkg::gcr_out_t result,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);
    import gcr_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_INS_LAST = 3'd2;
    localparam logic [2:0] S_LK_FIRST = 3'd3;
    localparam logic [2:0] S_LK_SCAN  = 3'd4;
    localparam logic [2:0] S_DIV      = 3'd5;
    localparam logic [2:0] S_PICK     = 3'd6;
    localparam logic [2:0] S_BLEND    = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             smooth_reg;
    logic [IDX_W-1:0] k_reg, k_next;
    gcr_stop_t        new_reg, new_next;
    gcr_stop_t        prev_reg, prev_next;
    logic [RGB_W-1:0] hi_rgb_reg, hi_rgb_next;
    logic [POS_W-1:0] span_reg, span_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [DSTEP_W-1:0] dstep_reg, dstep_next;
    logic [1:0]       chan_reg, chan_next;
    logic [RGB_W-1:0] res_rgb_reg, res_rgb_next;
    logic             done_reg, done_next;
    gcr_out_t         result_reg, result_next;

    // Stop memory: one write and one registered read per cycle
    gcr_stop_t        stop_mem [MAX_STOPS];
    gcr_stop_t        rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    gcr_stop_t        wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stop_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stop_mem[rd_addr];
    end

    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] k_inc;
    logic [IDX_W-1:0] k_dec;
    assign cnt_m1 = count_reg - CNT_W'(1);
    assign k_inc  = k_reg + IDX_W'(1);
    assign k_dec  = k_reg - IDX_W'(1);

    // Divider step: compare and subtract
    logic             div_ge;
    logic [REM_W-1:0] div_sub;
    logic [REM_W-1:0] div_keep;
    assign div_ge   = rem_reg >= {1'b0, span_reg};
    assign div_sub  = rem_reg - {1'b0, span_reg};
    assign div_keep = div_ge ? div_sub : rem_reg;

    // Shared blend multiplier, one channel per cycle
    logic [CH_W-1:0]         ch_c0;
    logic [CH_W-1:0]         ch_c1;
    logic signed [CH_W:0]    ch_diff;
    logic signed [Q_W:0]     w_s;
    logic signed [ACC_W-1:0] ch_prod;
    logic signed [ACC_W-1:0] ch_acc;
    logic [CH_W-1:0]         ch_out;

    always_comb
    begin
        case (chan_reg)
            2'd0:
            begin
                ch_c0 = prev_reg.rgb[3*CH_W-1:2*CH_W];
                ch_c1 = hi_rgb_reg[3*CH_W-1:2*CH_W];
            end
            2'd1:
            begin
                ch_c0 = prev_reg.rgb[2*CH_W-1:CH_W];
                ch_c1 = hi_rgb_reg[2*CH_W-1:CH_W];
            end
            default:
            begin
                ch_c0 = prev_reg.rgb[CH_W-1:0];
                ch_c1 = hi_rgb_reg[CH_W-1:0];
            end
        endcase
    end

    assign ch_diff = $signed({1'b0, ch_c1}) - $signed({1'b0, ch_c0});
    assign w_s     = $signed({1'b0, q_reg});
    assign ch_prod = ch_diff * w_s;
    assign ch_acc  = ch_prod + $signed({{(ACC_W-CH_W-FRAC_W){1'b0}}, ch_c0, {FRAC_W{1'b0}}});
    assign ch_out  = ch_acc[FRAC_W+CH_W-1:FRAC_W];

    logic             fin;
    logic [RGB_W-1:0] fin_rgb;
    logic             fin_status;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        new_next     = new_reg;
        prev_next    = prev_reg;
        hi_rgb_next  = hi_rgb_reg;
        span_next    = span_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        dstep_next   = dstep_reg;
        chan_next    = chan_reg;
        res_rgb_next = res_rgb_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        rd_addr      = k_reg;
        wr_en        = 1'b0;
        wr_addr      = k_inc;
        wr_data      = new_reg;
        fin          = 1'b0;
        fin_rgb      = '0;
        fin_status   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    new_next.pos = item.position;
                    new_next.rgb = {item.stop_red, item.stop_green, item.stop_blue};
                    case (item.operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            fin        = 1'b1;
                        end
                        OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_STOPS))
                            begin
                                fin        = 1'b1;
                                fin_status = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = new_next;
                                count_next = CNT_W'(1);
                                fin        = 1'b1;
                            end
                            else
                            begin
                                k_next     = cnt_m1[IDX_W-1:0];
                                rd_addr    = cnt_m1[IDX_W-1:0];
                                state_next = S_INS;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                fin     = 1'b1;
                                fin_rgb = WHITE_RGB;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                state_next = S_LK_FIRST;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                wr_en   = 1'b1;
                wr_addr = k_inc;
                if (rd_data_reg.pos > new_reg.pos)
                begin
                    // move this stop up one slot and keep walking down
                    wr_data = rd_data_reg;
                    if (k_reg == '0)
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        k_next  = k_dec;
                        rd_addr = k_dec;
                    end
                end
                else
                begin
                    wr_data    = new_reg;
                    count_next = count_reg + CNT_W'(1);
                    fin        = 1'b1;
                end
            end
            S_INS_LAST:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = new_reg;
                count_next = count_reg + CNT_W'(1);
                fin        = 1'b1;
            end
            S_LK_FIRST:
            begin
                if (count_reg == CNT_W'(1) || new_reg.pos < rd_data_reg.pos)
                begin
                    fin     = 1'b1;
                    fin_rgb = rd_data_reg.rgb;
                end
                else
                begin
                    prev_next  = rd_data_reg;
                    k_next     = IDX_W'(1);
                    rd_addr    = IDX_W'(1);
                    state_next = S_LK_SCAN;
                end
            end
            S_LK_SCAN:
            begin
                if (prev_reg.pos <= new_reg.pos && new_reg.pos <= rd_data_reg.pos)
                begin
                    if (rd_data_reg.pos == prev_reg.pos)
                    begin
                        fin     = 1'b1;
                        fin_rgb = rd_data_reg.rgb;
                    end
                    else
                    begin
                        span_next   = rd_data_reg.pos - prev_reg.pos;
                        rem_next    = {1'b0, new_reg.pos - prev_reg.pos};
                        q_next      = '0;
                        dstep_next  = '0;
                        hi_rgb_next = rd_data_reg.rgb;
                        state_next  = S_DIV;
                    end
                end
                else if (k_reg == cnt_m1[IDX_W-1:0])
                begin
                    // past the last stop
                    fin     = 1'b1;
                    fin_rgb = rd_data_reg.rgb;
                end
                else
                begin
                    prev_next = rd_data_reg;
                    k_next    = k_inc;
                    rd_addr   = k_inc;
                end
            end
            S_DIV:
            begin
                rem_next = {div_keep[REM_W-2:0], 1'b0};
                q_next   = {q_reg[Q_W-2:0], div_ge};
                if (dstep_reg == DSTEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    dstep_next = dstep_reg + DSTEP_W'(1);
                end
            end
            S_PICK:
            begin
                if (smooth_reg)
                begin
                    chan_next  = '0;
                    state_next = S_BLEND;
                end
                else
                begin
                    fin     = 1'b1;
                    fin_rgb = (q_reg >= Q_W'(HALF_Q16)) ? hi_rgb_reg : prev_reg.rgb;
                end
            end
            S_BLEND:
            begin
                res_rgb_next = {res_rgb_reg[2*CH_W-1:0], ch_out};
                if (chan_reg == 2'd2)
                begin
                    fin     = 1'b1;
                    fin_rgb = {res_rgb_reg[2*CH_W-1:0], ch_out};
                end
                else
                begin
                    chan_next = chan_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            done_next          = 1'b1;
            result_next.out_red   = fin_rgb[3*CH_W-1:2*CH_W];
            result_next.out_green = fin_rgb[2*CH_W-1:CH_W];
            result_next.out_blue  = fin_rgb[CH_W-1:0];
            result_next.status    = fin_status;
            state_next         = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            smooth_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                smooth_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        new_reg     <= new_next;
        prev_reg    <= prev_next;
        hi_rgb_reg  <= hi_rgb_next;
        span_reg    <= span_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        dstep_reg   <= dstep_next;
        chan_reg    <= chan_next;
        res_rgb_reg <= res_rgb_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_STOPS))
        else $error("stop count beyond table depth");

    a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.operation != OP_ADD && item.operation != OP_LOOKUP)
        |=> (done && !busy))
        else $error("clear or unused operation did not finish in one cycle");

    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |->
        (result.out_red == '0 && result.out_green == '0 && result.out_blue == '0))
        else $error("refused add carries a color");

    a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.operation == OP_ADD && count_reg == CNT_W'(MAX_STOPS))
        |=> (done && result.status))
        else $error("add into full table not refused");
`endif

endmodule
